>>> hdl/frame_rate_window_meter_defines.svh
// Assertion macros shared by the frame rate window meter RTL.
`ifndef FRAME_RATE_WINDOW_METER_DEFINES_SVH
`define FRAME_RATE_WINDOW_METER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define FRWM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("frame rate window meter check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define FRWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("frame rate window meter check failed");

`endif

>>> hdl/frwm_pkg.sv
// Shared constants, payload types and controller/datapath link types.
`default_nettype none

package frwm_pkg;

    localparam int TIME_BITS      = 32;
    localparam int RATE_BITS      = 24;
    localparam int RATE_FRAC_BITS = 8;
    localparam int COUNT_BITS     = 32;
    localparam int WSIZE_BITS     = 9;
    localparam int INTERVAL_BITS  = 32;
    localparam int TPS_BITS       = 30;
    localparam int CFG_DATA_BITS  = 32;
    localparam int CFG_INDEX_BITS = 2;
    localparam int MAX_WINDOW_DEF = 256;

    localparam logic [WSIZE_BITS-1:0]    WSIZE_RST    = WSIZE_BITS'(250);
    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RST = INTERVAL_BITS'(200000);
    localparam logic [TPS_BITS-1:0]      TPS_RST      = TPS_BITS'(1000000);
    localparam logic [RATE_BITS-1:0]     RATE_MAX     = {RATE_BITS{1'b1}};

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_WINDOW_SIZE      = t_cfg_index'(0);
    localparam t_cfg_index CFG_UPDATE_INTERVAL  = t_cfg_index'(1);
    localparam t_cfg_index CFG_TICKS_PER_SECOND = t_cfg_index'(2);

    typedef struct packed {
        logic [TIME_BITS-1:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_BITS-1:0] frame_count;
        logic [TIME_BITS-1:0]  frame_ticks;
        logic [RATE_BITS-1:0]  frame_rate;
        logic [RATE_BITS-1:0]  recent_rate;
        logic                  recent_updated;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // take the timestamp, count the frame
        logic first;       // first frame after reset: record time only
        logic rate_start;  // start rate division, read oldest sample
        logic rate_take;   // store saturated rate
        logic push;        // write sample, update sum and count
        logic avg_start;   // start average division
        logic avg_take;    // store average, record refresh time
        logic load_out;    // load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic refresh_due;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> hdl/frwm_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
`default_nettype none

interface frwm_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/frwm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module frwm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hdl/frwm_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module frwm_div #(
    parameter int DVD_W = 38,
    parameter int DVS_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        w_ge    = (w_shift >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DVD_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - CNT_W'(1);
                r_done <= (r_cnt == CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = (r_cnt != '0);
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> hdl/frwm_datapath.sv
// Datapath: configuration, frame timing, sample window, shared divider, result register.
`default_nettype none

module frwm_datapath #(
    parameter int MAX_WINDOW = frwm_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire frwm_pkg::t_cfg_index                 i_cfg_index,
    input  wire logic [frwm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire logic [frwm_pkg::TIME_BITS-1:0]       i_timestamp,
    input  wire frwm_pkg::t_dp_cmd                    i_cmd,
    output frwm_pkg::t_dp_stat                        o_stat,
    output frwm_pkg::t_out_item                       o_result
);

    import frwm_pkg::*;

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = RATE_BITS + $clog2(MAX_WINDOW);
    localparam int NUM_W = TPS_BITS + RATE_FRAC_BITS;
    localparam int DVD_W = (NUM_W > SUM_W) ? NUM_W : SUM_W;
    localparam int DVS_W = (TIME_BITS >= CNT_W) ? TIME_BITS : CNT_W;

    // Configuration
    logic [WSIZE_BITS-1:0]    r_wsize;
    logic [INTERVAL_BITS-1:0] r_interval;
    logic [TPS_BITS-1:0]      r_tps;

    // Frame timing
    logic [TIME_BITS-1:0]  r_ts;
    logic [TIME_BITS-1:0]  r_prev;
    logic [TIME_BITS-1:0]  r_last;
    logic [TIME_BITS-1:0]  r_delta;
    logic [TIME_BITS-1:0]  r_elapsed;
    logic [COUNT_BITS-1:0] r_frames;

    // Window
    logic [PTR_W-1:0]     r_wp;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_drop;
    logic [RATE_BITS-1:0] r_rate;
    logic [RATE_BITS-1:0] r_avg;
    logic                 r_updated;

    t_out_item r_out;

    logic [CNT_W-1:0]     w_limit;
    logic [CNT_W:0]       w_old_sum;
    logic [PTR_W-1:0]     w_old_addr;
    logic [PTR_W-1:0]     w_wp_next;
    logic [RATE_BITS-1:0] w_old;
    logic [RATE_BITS-1:0] w_rate_sat;
    logic                 w_div_start;
    logic [DVD_W-1:0]     w_dividend;
    logic [DVS_W-1:0]     w_divisor;
    logic [DVD_W-1:0]     w_quo;
    logic                 w_div_busy;
    logic                 w_div_done;

    // Clamp window size to 1..MAX_WINDOW; locate the oldest sample.
    always_comb begin
        if (r_wsize == '0) begin
            w_limit = CNT_W'(1);
        end else if (32'(r_wsize) > 32'(MAX_WINDOW)) begin
            w_limit = CNT_W'(MAX_WINDOW);
        end else begin
            w_limit = CNT_W'(r_wsize);
        end
        w_old_sum = (CNT_W + 1)'(r_wp) + (CNT_W + 1)'(MAX_WINDOW) - (CNT_W + 1)'(r_cnt);
        if (w_old_sum >= (CNT_W + 1)'(MAX_WINDOW)) begin
            w_old_addr = PTR_W'(w_old_sum - (CNT_W + 1)'(MAX_WINDOW));
        end else begin
            w_old_addr = PTR_W'(w_old_sum);
        end
        w_wp_next = (32'(r_wp) == 32'(MAX_WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
    end

    // Share one divider between rate and average.
    always_comb begin
        w_div_start = i_cmd.rate_start | i_cmd.avg_start;
        if (i_cmd.rate_start) begin
            w_dividend = DVD_W'({r_tps, {RATE_FRAC_BITS{1'b0}}});
            w_divisor  = DVS_W'(r_delta);
        end else begin
            w_dividend = DVD_W'(r_sum);
            w_divisor  = DVS_W'(r_cnt);
        end
        w_rate_sat = (w_quo[DVD_W-1:RATE_BITS] != '0) ? RATE_MAX : w_quo[RATE_BITS-1:0];
    end

    frwm_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    frwm_ram #(
        .WIDTH (RATE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_wp),
        .i_wdata (r_rate),
        .i_re    (i_cmd.rate_start),
        .i_raddr (w_old_addr),
        .o_rdata (w_old)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize    <= WSIZE_RST;
            r_interval <= INTERVAL_RST;
            r_tps      <= TPS_RST;
            r_prev     <= '0;
            r_last     <= '0;
            r_frames   <= '0;
            r_avg      <= '0;
            r_wp       <= '0;
            r_cnt      <= '0;
            r_sum      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WINDOW_SIZE: begin
                        r_wsize <= i_cfg_data[WSIZE_BITS-1:0];
                        r_wp    <= '0;
                        r_cnt   <= '0;
                        r_sum   <= '0;
                    end
                    CFG_UPDATE_INTERVAL: begin
                        r_interval <= i_cfg_data[INTERVAL_BITS-1:0];
                    end
                    CFG_TICKS_PER_SECOND: begin
                        r_tps <= i_cfg_data[TPS_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.capture) begin
                r_frames <= r_frames + COUNT_BITS'(1);
                r_prev   <= i_timestamp;
                if (i_cmd.first) begin
                    r_last <= i_timestamp;
                end
            end
            if (i_cmd.push) begin
                r_wp  <= w_wp_next;
                r_cnt <= r_drop ? r_cnt : r_cnt + CNT_W'(1);
                r_sum <= r_sum + SUM_W'(r_rate) - (r_drop ? SUM_W'(w_old) : SUM_W'(0));
            end
            if (i_cmd.avg_take) begin
                r_avg  <= w_quo[RATE_BITS-1:0];
                r_last <= r_ts;
            end
        end
    end

    // Per-frame payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ts      <= i_timestamp;
            r_delta   <= i_cmd.first ? '0 : i_timestamp - r_prev;
            r_elapsed <= i_timestamp - r_last;
            r_rate    <= '0;
            r_updated <= 1'b0;
        end
        if (i_cmd.rate_start) begin
            r_drop <= (r_cnt >= w_limit);
        end
        if (i_cmd.rate_take) begin
            r_rate <= w_rate_sat;
        end
        if (i_cmd.avg_take) begin
            r_updated <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_out.frame_count    <= r_frames;
            r_out.frame_ticks    <= r_delta;
            r_out.frame_rate     <= r_rate;
            r_out.recent_rate    <= r_avg;
            r_out.recent_updated <= r_updated;
        end
    end

    assign o_stat.div_busy    = w_div_busy;
    assign o_stat.div_done    = w_div_done;
    assign o_stat.refresh_due = (r_elapsed > r_interval);
    assign o_result           = r_out;

endmodule

`default_nettype wire

>>> hdl/frwm_ctrl.sv
// Controller: sequences capture, rate division, window push, averaging and output.
`default_nettype none

module frwm_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output frwm_pkg::t_dp_cmd       o_cmd,
    input  wire frwm_pkg::t_dp_stat i_stat
);

    import frwm_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_RATE      = 3'd1;
    localparam logic [2:0] S_RATE_WAIT = 3'd2;
    localparam logic [2:0] S_PUSH      = 3'd3;
    localparam logic [2:0] S_AVG       = 3'd4;
    localparam logic [2:0] S_AVG_WAIT  = 3'd5;
    localparam logic [2:0] S_DONE      = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_started;
    logic       r_out_valid;
    logic       w_slot_free;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        w_slot_free = !r_out_valid || i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.first   = !r_started;
                    n_state       = r_started ? S_RATE : S_DONE;
                end
            end
            S_RATE: begin
                o_cmd.rate_start = 1'b1;
                n_state          = S_RATE_WAIT;
            end
            S_RATE_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.rate_take = 1'b1;
                    n_state         = S_PUSH;
                end
            end
            S_PUSH: begin
                o_cmd.push = 1'b1;
                n_state    = i_stat.refresh_due ? S_AVG : S_DONE;
            end
            S_AVG: begin
                o_cmd.avg_start = 1'b1;
                n_state         = S_AVG_WAIT;
            end
            S_AVG_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.avg_take = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.capture) begin
                r_started <= 1'b1;
            end
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> hdl/frame_rate_window_meter.sv
// Top level of the frame rate window meter: controller, datapath and stream ports.
// One item is in work at a time: the shared 38-step divider runs once for the rate and,
// when the recent rate is refreshed, once more for the average; the first frame after
// reset only records its time and skips both. A finished result waits in its own
// register, so the next item can be taken while it is still pending. Reset (i_rst_n,
// synchronous, active low) restores the register defaults and empties the window.
`default_nettype none

`include "frame_rate_window_meter_defines.svh"

module frame_rate_window_meter #(
    parameter int MAX_WINDOW = frwm_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire frwm_pkg::t_cfg_index               i_cfg_index,
    input  wire logic [frwm_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    frwm_stream_if.sink                             i_item,
    frwm_stream_if.source                           o_result
);

    import frwm_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_out_item w_out;
    logic      w_in_ready;
    logic      w_out_valid;

    // The controller walks each frame through: capture timestamp, divide ticks/second
    // by the delta (while the oldest window sample is read), push the rate into the
    // ring and update the running sum, then divide sum by count when the refresh
    // interval has elapsed. The first frame after reset only records the time.
    frwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    // The datapath holds configuration, timing state, the sample ring, the divider
    // and the result register. Writing the window size empties the window.
    frwm_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_timestamp (i_item.data.timestamp),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_result    (w_out)
    );

    // Drive the stream handshakes.
    assign i_item.ready   = w_in_ready;
    assign o_result.valid = w_out_valid;
    assign o_result.data  = w_out;

    // One frame in work at a time: a transfer in closes the input until the result is loaded.
    `FRWM_ASSERT_NEXT(a_one_in_flight, i_item.valid && i_item.ready, !i_item.ready)
    // Never start a division while the divider is still iterating.
    `FRWM_ASSERT_IMPL(a_div_idle_on_start, w_cmd.rate_start || w_cmd.avg_start, !w_stat.div_busy)
    // Never overwrite a result that has not been transferred.
    `FRWM_ASSERT_IMPL(a_no_result_overrun, w_cmd.load_out, !o_result.valid || o_result.ready)

endmodule

`default_nettype wire
